### rtl/keyed_vigenere_decrypt_macros.svh
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt assertion macros
// Shared shorthand for the concurrent checks of the decryptor.
// ----------------------------------------------------------------------------
`ifndef KEYED_VIGENERE_DECRYPT_MACROS_SVH
`define KEYED_VIGENERE_DECRYPT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_vigenere_decrypt: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define KVD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_vigenere_decrypt: assertion failed");

`endif

### rtl/kvd_pkg.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt package
// Shared constants, register indexes, item types and helpers.
// ----------------------------------------------------------------------------
package kvd_pkg;

    localparam int ALPHABET_MAX_DEF = 32;
    localparam int KEY_MAX_DEF      = 16;

    localparam int SYM_W         = 8;
    localparam int SYMS_PER_WORD = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int ALPHA_LEN_W   = 6;
    localparam int KEY_LEN_W     = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LO    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN   = 3'd7;

    localparam logic [SYM_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [SYM_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [SYM_W-1:0] ASCII_CASE    = 8'h20;

    typedef struct packed {
        logic [SYM_W-1:0] cipher_byte;
        logic             first;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] plain_byte;
        logic             was_decrypted;
    } out_item_t;

    function automatic logic [SYM_W-1:0] to_upper(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] r;
        r = c;
        if (c inside {[ASCII_LOWER_A:ASCII_LOWER_Z]})
        begin
            r = c - ASCII_CASE;
        end
        return r;
    endfunction

endpackage

### rtl/kvd_in_if.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt input channel
// Valid/ready channel that carries one ciphertext byte per transaction.
// ----------------------------------------------------------------------------
interface kvd_in_if;
    import kvd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] cipher_byte;
    logic             first;

    modport source (output valid, output cipher_byte, output first, input ready);
    modport sink (input valid, input cipher_byte, input first, output ready);
endinterface

### rtl/kvd_out_if.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt output channel
// Valid/ready channel that carries one plaintext byte per transaction.
// ----------------------------------------------------------------------------
interface kvd_out_if;
    import kvd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] plain_byte;
    logic             was_decrypted;

    modport source (output valid, output plain_byte, output was_decrypted, input ready);
    modport sink (input valid, input plain_byte, input was_decrypted, output ready);
endinterface

### rtl/keyed_vigenere_decrypt.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt
// An accepted transaction moves from the input register into the result register and leaves from there.
// Throughput is one byte per cycle while the output is ready; input ready drops only when both registers are full.
// The input register feeds the alphabet match and key shift, which load the result register.
// Reset clears both valid flags, the key position and the alphabet and key registers, and sets both lengths to one.
// ----------------------------------------------------------------------------
`include "keyed_vigenere_decrypt_macros.svh"

module keyed_vigenere_decrypt #(
    parameter int ALPHABET_MAX = kvd_pkg::ALPHABET_MAX_DEF,
    parameter int KEY_MAX      = kvd_pkg::KEY_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kvd_in_if.sink                          in_ch,
    kvd_out_if.source                       out_ch,
    input  logic                            wr_en,
    input  logic [kvd_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [kvd_pkg::CFG_DATA_W-1:0]  wr_data
);
    import kvd_pkg::*;

    localparam int LW  = $clog2(ALPHABET_MAX + 1);
    localparam int IW  = $clog2(ALPHABET_MAX);
    localparam int KLW = $clog2(KEY_MAX + 1);
    localparam int PW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [SYM_W-1:0] alpha_syms [ALPHABET_MAX];
    logic [LW-1:0]    alpha_len;
    logic [SYM_W-1:0] key_syms [KEY_MAX];
    logic [KLW-1:0]   key_len;

    logic             a_valid_reg;
    in_item_t         a_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic [PW-1:0]    key_pos_reg;
    logic [PW-1:0]    key_pos_next;

    logic             out_adv;
    logic             a_adv;
    logic             a_fire;
    logic             a_hit;
    logic [IW-1:0]    a_idx;
    out_item_t        result;

    kvd_cfg #(
        .ALPHABET_MAX (ALPHABET_MAX),
        .KEY_MAX      (KEY_MAX)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .alpha_syms (alpha_syms),
        .alpha_len  (alpha_len),
        .key_syms   (key_syms),
        .key_len    (key_len)
    );

    assign out_adv     = !out_valid_reg || out_ch.ready;
    assign a_adv       = !a_valid_reg || out_adv;
    assign a_fire      = a_valid_reg && out_adv;
    assign in_ch.ready = a_adv;

    kvd_lookup #(
        .ALPHABET_MAX (ALPHABET_MAX)
    ) u_cipher_lookup (
        .alpha_syms (alpha_syms),
        .alpha_len  (alpha_len),
        .sym        (a_item_reg.cipher_byte),
        .hit        (a_hit),
        .idx        (a_idx)
    );

    kvd_decrypt #(
        .ALPHABET_MAX (ALPHABET_MAX),
        .KEY_MAX      (KEY_MAX)
    ) u_decrypt (
        .alpha_syms   (alpha_syms),
        .alpha_len    (alpha_len),
        .key_syms     (key_syms),
        .key_len      (key_len),
        .key_pos      (key_pos_reg),
        .cipher_byte  (a_item_reg.cipher_byte),
        .first        (a_item_reg.first),
        .hit          (a_hit),
        .idx          (a_idx),
        .result       (result),
        .key_pos_next (key_pos_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            key_pos_reg   <= '0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= in_ch.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= a_valid_reg;
            end
            if (a_fire)
            begin
                key_pos_reg <= key_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && a_adv)
        begin
            a_item_reg.cipher_byte <= in_ch.cipher_byte;
            a_item_reg.first       <= in_ch.first;
        end
        if (a_fire)
        begin
            out_item_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.plain_byte    = out_item_reg.plain_byte;
    assign out_ch.was_decrypted = out_item_reg.was_decrypted;

    // The key position moves only when a transaction leaves the input register.
    `KVD_ASSERT_NEXT(a_key_pos_hold, !a_fire, $stable(key_pos_reg))
    // A byte outside the alphabet reaches the output unchanged.
    `KVD_ASSERT_NEXT(a_pass_through, a_fire && !a_hit,
        !out_item_reg.was_decrypted && (out_item_reg.plain_byte == $past(a_item_reg.cipher_byte)))
    // A stalled input register keeps its transaction.
    `KVD_ASSERT_NEXT(a_stage_hold, a_valid_reg && !out_adv,
        a_valid_reg && $stable(a_item_reg))
endmodule

### rtl/kvd_cfg.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt configuration registers
// Holds the alphabet, the key and their clamped lengths.
// ----------------------------------------------------------------------------
module kvd_cfg #(
    parameter int ALPHABET_MAX = kvd_pkg::ALPHABET_MAX_DEF,
    parameter int KEY_MAX      = kvd_pkg::KEY_MAX_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [kvd_pkg::CFG_INDEX_W-1:0]       wr_index,
    input  logic [kvd_pkg::CFG_DATA_W-1:0]        wr_data,
    output logic [kvd_pkg::SYM_W-1:0]             alpha_syms [ALPHABET_MAX],
    output logic [$clog2(ALPHABET_MAX+1)-1:0]     alpha_len,
    output logic [kvd_pkg::SYM_W-1:0]             key_syms [KEY_MAX],
    output logic [$clog2(KEY_MAX+1)-1:0]          key_len
);
    import kvd_pkg::*;

    localparam int LW  = $clog2(ALPHABET_MAX + 1);
    localparam int KLW = $clog2(KEY_MAX + 1);

    logic [SYM_W-1:0]       alpha_reg [ALPHABET_MAX];
    logic [SYM_W-1:0]       key_reg [KEY_MAX];
    logic [LW-1:0]          alen_reg;
    logic [LW-1:0]          alen_next;
    logic [KLW-1:0]         klen_reg;
    logic [KLW-1:0]         klen_next;
    logic [ALPHA_LEN_W-1:0] alen_raw;
    logic [KEY_LEN_W-1:0]   klen_raw;

    assign alen_raw = wr_data[ALPHA_LEN_W-1:0];
    assign klen_raw = wr_data[KEY_LEN_W-1:0];

    always_comb
    begin
        if (alen_raw == '0)
        begin
            alen_next = LW'(1);
        end
        else if (alen_raw > ALPHA_LEN_W'(ALPHABET_MAX))
        begin
            alen_next = LW'(ALPHABET_MAX);
        end
        else
        begin
            alen_next = LW'(alen_raw);
        end
        if (klen_raw == '0)
        begin
            klen_next = KLW'(1);
        end
        else if (klen_raw > KEY_LEN_W'(KEY_MAX))
        begin
            klen_next = KLW'(KEY_MAX);
        end
        else
        begin
            klen_next = KLW'(klen_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ALPHABET_MAX; j++)
            begin
                alpha_reg[j] <= '0;
            end
            for (int j = 0; j < KEY_MAX; j++)
            begin
                key_reg[j] <= '0;
            end
            alen_reg <= LW'(1);
            klen_reg <= KLW'(1);
        end
        else if (wr_en)
        begin
            for (int j = 0; j < ALPHABET_MAX; j++)
            begin
                if (wr_index == REG_ALPHA_0 + CFG_INDEX_W'(j / SYMS_PER_WORD))
                begin
                    alpha_reg[j] <= wr_data[(j % SYMS_PER_WORD) * SYM_W +: SYM_W];
                end
            end
            for (int j = 0; j < KEY_MAX; j++)
            begin
                if (wr_index == REG_KEY_LO + CFG_INDEX_W'(j / SYMS_PER_WORD))
                begin
                    key_reg[j] <= wr_data[(j % SYMS_PER_WORD) * SYM_W +: SYM_W];
                end
            end
            if (wr_index == REG_ALPHA_LEN)
            begin
                alen_reg <= alen_next;
            end
            if (wr_index == REG_KEY_LEN)
            begin
                klen_reg <= klen_next;
            end
        end
    end

    assign alpha_syms = alpha_reg;
    assign key_syms   = key_reg;
    assign alpha_len  = alen_reg;
    assign key_len    = klen_reg;
endmodule

### rtl/kvd_lookup.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt alphabet lookup
// Parallel compare of one symbol against the active alphabet, lowest wins.
// ----------------------------------------------------------------------------
module kvd_lookup #(
    parameter int ALPHABET_MAX = kvd_pkg::ALPHABET_MAX_DEF
) (
    input  logic [kvd_pkg::SYM_W-1:0]         alpha_syms [ALPHABET_MAX],
    input  logic [$clog2(ALPHABET_MAX+1)-1:0] alpha_len,
    input  logic [kvd_pkg::SYM_W-1:0]         sym,
    output logic                              hit,
    output logic [$clog2(ALPHABET_MAX)-1:0]   idx
);
    import kvd_pkg::*;

    localparam int LW = $clog2(ALPHABET_MAX + 1);
    localparam int IW = $clog2(ALPHABET_MAX);

    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int i = ALPHABET_MAX - 1; i >= 0; i--)
        begin
            if ((LW'(i) < alpha_len) && (alpha_syms[i] == sym))
            begin
                hit = 1'b1;
                idx = IW'(i);
            end
        end
    end
endmodule

### rtl/kvd_decrypt.sv
// ----------------------------------------------------------------------------
// Keyed Vigenere decrypt shift stage
// Key character lookup, modular subtraction and key position update.
// ----------------------------------------------------------------------------
module kvd_decrypt #(
    parameter int ALPHABET_MAX = kvd_pkg::ALPHABET_MAX_DEF,
    parameter int KEY_MAX      = kvd_pkg::KEY_MAX_DEF,
    localparam int PW          = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  logic [kvd_pkg::SYM_W-1:0]         alpha_syms [ALPHABET_MAX],
    input  logic [$clog2(ALPHABET_MAX+1)-1:0] alpha_len,
    input  logic [kvd_pkg::SYM_W-1:0]         key_syms [KEY_MAX],
    input  logic [$clog2(KEY_MAX+1)-1:0]      key_len,
    input  logic [PW-1:0]                     key_pos,
    input  logic [kvd_pkg::SYM_W-1:0]         cipher_byte,
    input  logic                              first,
    input  logic                              hit,
    input  logic [$clog2(ALPHABET_MAX)-1:0]   idx,
    output kvd_pkg::out_item_t                result,
    output logic [PW-1:0]                     key_pos_next
);
    import kvd_pkg::*;

    localparam int LW  = $clog2(ALPHABET_MAX + 1);
    localparam int IW  = $clog2(ALPHABET_MAX);
    localparam int DW  = LW + 1;
    localparam int KLW = $clog2(KEY_MAX + 1);

    logic [PW-1:0]    pos_use;
    logic [KLW-1:0]   pos_inc;
    logic [PW-1:0]    pos_wrap;
    logic [SYM_W-1:0] key_upper;
    logic             key_hit;
    logic [IW-1:0]    key_idx;
    logic [DW-1:0]    diff0;
    logic [DW-1:0]    diff1;
    logic [DW-1:0]    diff2;

    always_comb
    begin
        if (first || (KLW'(key_pos) >= key_len))
        begin
            pos_use = '0;
        end
        else
        begin
            pos_use = key_pos;
        end
        key_upper = to_upper(key_syms[pos_use]);
    end

    kvd_lookup #(
        .ALPHABET_MAX (ALPHABET_MAX)
    ) u_key_lookup (
        .alpha_syms (alpha_syms),
        .alpha_len  (alpha_len),
        .sym        (key_upper),
        .hit        (key_hit),
        .idx        (key_idx)
    );

    always_comb
    begin
        diff0 = DW'(idx) + DW'(alpha_len) + DW'(!key_hit)
              - (key_hit ? DW'(key_idx) : DW'(0));
        diff1 = (diff0 >= DW'(alpha_len)) ? diff0 - DW'(alpha_len) : diff0;
        diff2 = (diff1 >= DW'(alpha_len)) ? diff1 - DW'(alpha_len) : diff1;

        pos_inc  = KLW'(pos_use) + KLW'(1);
        pos_wrap = (pos_inc >= key_len) ? '0 : pos_inc[PW-1:0];

        if (hit)
        begin
            result.plain_byte    = alpha_syms[diff2[IW-1:0]];
            result.was_decrypted = 1'b1;
            key_pos_next         = pos_wrap;
        end
        else
        begin
            result.plain_byte    = cipher_byte;
            result.was_decrypted = 1'b0;
            key_pos_next         = first ? '0 : key_pos;
        end
    end
endmodule
